### rtl/lzss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LZSS decompressor package
// Shared types and constants for the 4 KiB window LZSS decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

    localparam int unsigned WINDOW_SIZE_DEF = 4096;

    localparam logic [11:0] WP_START  = 12'hFF0;
    localparam logic [7:0]  FILL_BYTE = 8'h20;
    localparam logic [3:0]  TYPE_BITS = 4'd8;

    localparam logic CMD_DATA    = 1'b0;
    localparam logic CMD_RESTART = 1'b1;

    typedef enum logic [1:0] {
        S_CLR,
        S_IDLE,
        S_RD,
        S_EMIT
    } t_state;

    typedef enum logic [1:0] {
        PH_FLAG = 2'd0,
        PH_DATA = 2'd1,
        PH_PAIR = 2'd2
    } t_phase;

endpackage

### rtl/lzss_window_decompressor.sv
`timescale 1ns / 1ps
// A literal is registered at the edge that accepts it and is offered the next cycle.
// Copy pairs, 3 to 18 bytes: window read, then emit and write back, per byte.
// Flag bytes and first pair bytes are absorbed with no output.
// The 4096 x 8 window has one write port and one registered read port.
// Reset and the restart command run a clearing pass that fills every
// window entry with spaces; no input beat is taken until it completes.
// ----------------------------------------------------------------------------
// LZSS window decompressor
// Expands an SZDD-style LZSS body through a 4 KiB history window, one
// compressed byte per input beat and one decompressed byte per output beat.
// ----------------------------------------------------------------------------
module lzss_window_decompressor
    import lzss_pkg::*;
#(
    parameter int unsigned WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_cmd,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_last
);

    localparam int unsigned AW = $clog2(WINDOW_SIZE);
    localparam logic [AW-1:0] LAST_ADDR = AW'(WINDOW_SIZE - 1);

    logic [7:0] mem [WINDOW_SIZE];

    t_state          r_state, n_state;
    t_phase          r_phase, n_phase;
    logic [AW-1:0]   r_wp, n_wp;
    logic [AW-1:0]   r_pos, n_pos;
    logic [AW-1:0]   r_clr, n_clr;
    logic [7:0]      r_type_bits, n_type_bits;
    logic [3:0]      r_type_left, n_type_left;
    logic [7:0]      r_pend, n_pend;
    logic [4:0]      r_cnt, n_cnt;
    logic [7:0]      r_rdata;
    logic            r_out_valid, n_out_valid;
    logic [7:0]      r_out_byte, n_out_byte;
    logic            r_last, n_last;

    logic            w_en;
    logic [AW-1:0]   w_addr;
    logic [7:0]      w_data;
    logic            in_fire;
    logic            out_free;
    logic [7:0]      c_bits;
    logic [3:0]      c_left;
    t_phase          c_phase;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE) || !out_free;
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_last;

    assign c_bits  = r_type_bits >> 1;
    assign c_left  = (r_type_left == 4'd0) ? 4'd0 : r_type_left - 4'd1;
    assign c_phase = (c_left != 4'd0) ? PH_DATA : PH_FLAG;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_wp        = r_wp;
        n_pos       = r_pos;
        n_clr       = r_clr;
        n_type_bits = r_type_bits;
        n_type_left = r_type_left;
        n_pend      = r_pend;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_byte  = r_out_byte;
        n_last      = r_last;
        w_en        = 1'b0;
        w_addr      = r_wp;
        w_data      = r_rdata;
        case (r_state)
            S_CLR: begin
                w_en   = 1'b1;
                w_addr = r_clr;
                w_data = FILL_BYTE;
                n_clr  = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    if (i_cmd == CMD_RESTART) begin
                        n_state     = S_CLR;
                        n_clr       = '0;
                        n_wp        = AW'(WP_START);
                        n_type_bits = '0;
                        n_type_left = '0;
                        n_phase     = PH_FLAG;
                        n_pend      = '0;
                    end else begin
                        case (r_phase)
                            PH_DATA: begin
                                if (r_type_bits[0]) begin
                                    w_en        = 1'b1;
                                    w_data      = i_in_byte;
                                    n_wp        = r_wp + AW'(1);
                                    n_out_valid = 1'b1;
                                    n_out_byte  = i_in_byte;
                                    n_last      = 1'b1;
                                    n_type_bits = c_bits;
                                    n_type_left = c_left;
                                    n_phase     = c_phase;
                                end else begin
                                    n_pend  = i_in_byte;
                                    n_phase = PH_PAIR;
                                end
                            end
                            PH_PAIR: begin
                                n_pos   = AW'({i_in_byte[7:4], r_pend});
                                n_cnt   = {1'b0, i_in_byte[3:0]} + 5'd2;
                                n_state = S_RD;
                            end
                            default: begin
                                n_type_bits = i_in_byte;
                                n_type_left = TYPE_BITS;
                                n_phase     = PH_DATA;
                            end
                        endcase
                    end
                end
            end
            S_RD: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    w_en        = 1'b1;
                    n_wp        = r_wp + AW'(1);
                    n_pos       = r_pos + AW'(1);
                    n_out_valid = 1'b1;
                    n_out_byte  = r_rdata;
                    n_last      = (r_cnt == 5'd0);
                    if (r_cnt == 5'd0) begin
                        n_type_bits = c_bits;
                        n_type_left = c_left;
                        n_phase     = c_phase;
                        n_state     = S_IDLE;
                    end else begin
                        n_cnt   = r_cnt - 5'd1;
                        n_state = S_RD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[r_pos];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_phase     <= PH_FLAG;
            r_wp        <= AW'(WP_START);
            r_clr       <= '0;
            r_type_bits <= '0;
            r_type_left <= '0;
            r_pend      <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_wp        <= n_wp;
            r_clr       <= n_clr;
            r_type_bits <= n_type_bits;
            r_type_left <= n_type_left;
            r_pend      <= n_pend;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos      <= n_pos;
        r_out_byte <= n_out_byte;
        r_last     <= n_last;
    end

    a_clr_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> o_in_stall)
        else $error("input taken during window clear");

    a_last_ends_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free && r_cnt == 5'd0) |=> (r_state == S_IDLE))
        else $error("copy did not end after last byte");

    a_wp_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && out_free) |=> (r_wp == $past(r_wp) + AW'(1)))
        else $error("write pointer did not advance on copy byte");

    a_type_left_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_type_left <= TYPE_BITS)
        else $error("type bit count out of range");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
        |=> (o_out_valid && $stable(o_out_byte) && $stable(o_last)))
        else $error("stalled output beat changed");

endmodule
